// ===== src/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/b64c_pkg.sv =====
package b64c_pkg;

   localparam int GROUP_W          = 24;
   localparam int QUEUE_DEPTH_DEF  = 2;

   localparam logic       DIR_ENCODE = 1'b0;
   localparam logic       DIR_DECODE = 1'b1;
   localparam logic [7:0] PAD_CHAR   = 8'h3D;

   // One finished group handed from the front end to the back end.
   typedef struct packed {
      logic [GROUP_W-1:0] bits;
      logic               enc;
      logic [2:0]         nvalid;   // characters (encode) or bytes (decode)
      logic [1:0]         cnt_m1;   // results to emit, minus one
      logic               last;
      logic               marker;   // end-only result, no data
   } job_type;

   function automatic logic [7:0] char_of(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'h3E) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

   function automatic logic [5:0] value_of(input logic [7:0] c);
      logic [5:0] v;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         v = 6'h3E;
      end else if (c == 8'h2F) begin
         v = 6'h3F;
      end else begin
         v = 6'h00;
      end
      return v;
   endfunction

endpackage

// ===== src/b64c_front.sv =====
module b64c_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_in_byte,
   input  logic              req_in_last,
   input  logic              q_full,
   output logic              q_push,
   output b64c_pkg::job_type q_job
);

   logic                           dir_ff, dir_in;
   logic [b64c_pkg::GROUP_W-1:0]   bits_ff, bits_in;
   logic [1:0]                     phase_ff, phase_in;
   logic [1:0]                     pad_ff, pad_in;

   logic                           accept;
   logic [b64c_pkg::GROUP_W-1:0]   enc_bits, dec_bits;
   logic [2:0]                     enc_nbytes;
   logic [5:0]                     dval;
   logic [1:0]                     pad_nx;
   logic [2:0]                     nchars, ndata, nbytes;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      case (phase_ff)
         2'd0:    enc_bits = bits_ff | {req_in_byte, 16'h0000};
         2'd1:    enc_bits = bits_ff | {8'h00, req_in_byte, 8'h00};
         default: enc_bits = bits_ff | {16'h0000, req_in_byte};
      endcase
      enc_nbytes = (phase_ff >= 2'd2) ? 3'd3 : {1'b0, phase_ff} + 3'd1;

      dval = b64c_pkg::value_of(req_in_byte);
      case (phase_ff)
         2'd0:    dec_bits = bits_ff | {dval, 18'h0};
         2'd1:    dec_bits = bits_ff | {6'h0, dval, 12'h0};
         2'd2:    dec_bits = bits_ff | {12'h0, dval, 6'h0};
         default: dec_bits = bits_ff | {18'h0, dval};
      endcase
      if (req_in_byte == b64c_pkg::PAD_CHAR) begin
         pad_nx = (pad_ff == 2'd2) ? 2'd2 : pad_ff + 2'd1;
      end else begin
         pad_nx = 2'd0;
      end
      nchars = {1'b0, phase_ff} + 3'd1;
      ndata  = (nchars > {1'b0, pad_nx}) ? nchars - {1'b0, pad_nx} : 3'd0;
      nbytes = (ndata >= 3'd2) ? ndata - 3'd1 : 3'd0;
   end

   always_comb begin
      dir_in   = dir_ff;
      bits_in  = bits_ff;
      phase_in = phase_ff;
      pad_in   = pad_ff;
      q_push   = 1'b0;
      q_job    = '0;
      if (csr_wr_en) begin
         dir_in   = csr_wr_data;
         bits_in  = '0;
         phase_in = 2'd0;
         pad_in   = 2'd0;
      end else if (accept) begin
         if (dir_ff == b64c_pkg::DIR_ENCODE) begin
            if (enc_nbytes == 3'd3 || req_in_last) begin
               q_push       = 1'b1;
               q_job.bits   = enc_bits;
               q_job.enc    = 1'b1;
               q_job.nvalid = enc_nbytes + 3'd1;
               q_job.cnt_m1 = 2'd3;
               q_job.last   = req_in_last;
               bits_in      = '0;
               phase_in     = 2'd0;
               pad_in       = 2'd0;
            end else begin
               bits_in  = enc_bits;
               phase_in = enc_nbytes[1:0];
            end
         end else begin
            if (nchars == 3'd4 || req_in_last) begin
               // a non-final group always yields at least one byte
               q_push       = (nbytes != 3'd0) || req_in_last;
               q_job.bits   = dec_bits;
               q_job.enc    = 1'b0;
               q_job.nvalid = nbytes;
               q_job.cnt_m1 = (nbytes == 3'd0) ? 2'd0 : 2'(nbytes - 3'd1);
               q_job.last   = req_in_last;
               q_job.marker = (nbytes == 3'd0);
               bits_in      = '0;
               phase_in     = 2'd0;
               pad_in       = 2'd0;
            end else begin
               bits_in  = dec_bits;
               phase_in = nchars[1:0];
               pad_in   = pad_nx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= b64c_pkg::DIR_ENCODE;
         bits_ff  <= '0;
         phase_ff <= 2'd0;
         pad_ff   <= 2'd0;
      end else begin
         dir_ff   <= dir_in;
         bits_ff  <= bits_in;
         phase_ff <= phase_in;
         pad_ff   <= pad_in;
      end
   end

endmodule

// ===== src/b64c_queue.sv =====
module b64c_queue #(
   parameter int Depth = b64c_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64c_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output b64c_pkg::job_type head_job
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   b64c_pkg::job_type slot_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign head_job  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/b64c_back.sv =====
module b64c_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  b64c_pkg::job_type q_job,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_out_has_data,
   output logic              rsp_out_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       has_ff, has_in;
   logic       last_ff, last_in;
   logic [1:0] idx_ff, idx_in;

   logic       load;
   logic       at_end;
   logic [5:0] sextet;
   logic [7:0] octet;

   // the output register takes a new transaction when empty or being drained
   assign load   = q_not_empty && (!valid_ff || !rsp_stall);
   assign at_end = (idx_ff == q_job.cnt_m1);
   assign q_pop  = load && at_end;

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = q_job.bits[23:18];
         2'd1:    sextet = q_job.bits[17:12];
         2'd2:    sextet = q_job.bits[11:6];
         default: sextet = q_job.bits[5:0];
      endcase
      case (idx_ff)
         2'd0:    octet = q_job.bits[23:16];
         2'd1:    octet = q_job.bits[15:8];
         default: octet = q_job.bits[7:0];
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      has_in   = has_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         has_in   = !q_job.marker;
         last_in  = at_end && q_job.last;
         idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
         if (q_job.marker) begin
            byte_in = 8'h00;
         end else if (q_job.enc) begin
            byte_in = ({1'b0, idx_ff} < q_job.nvalid) ? b64c_pkg::char_of(sextet)
                                                       : b64c_pkg::PAD_CHAR;
         end else begin
            byte_in = octet;
         end
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      has_ff  <= has_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_out_has_data = has_ff;
   assign rsp_out_last     = last_ff;

endmodule

// ===== src/base64_stream_codec.sv =====
// Base64 stream codec, standard alphabet. csr_wr_data selects encode (0) or
// decode (1) and restarts the message. The front end takes one input byte
// per cycle and stalls only while its job queue (QueueDepth groups) is full;
// the back end drives one result per cycle from its output register unless
// rsp_stall holds it or no job is queued. An encoded group of three bytes
// gives four characters, so the single result port sets the encode rate;
// decode sustains one character per cycle while rsp_stall is low. A completed
// group is queued, and its results leave through the output register.
module base64_stream_codec #(
   parameter int QueueDepth = b64c_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_has_data,
   output logic       rsp_out_last
);

   logic              q_full, q_push, q_pop, q_not_empty;
   b64c_pkg::job_type push_job, head_job;

   b64c_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   b64c_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   b64c_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_job            (head_job),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_has_data (rsp_out_has_data),
      .rsp_out_last     (rsp_out_last)
   );

endmodule

// ===== src/b64c_checker.sv =====
`include "assert_macros.svh"

module b64c_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       req_in_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_has_data,
   input logic       rsp_out_last
);

   `ASSERT_CLK(a_req_hold, clock, reset, req_valid && req_stall |=> req_valid && $stable(req_in_byte) && $stable(req_in_last), "req changed while stalled")
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp dropped while stalled")
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_out_byte) && $stable(rsp_out_last), "rsp payload changed while stalled")
   `ASSERT_CLK(a_marker_form, clock, reset, rsp_valid && !rsp_out_has_data |-> rsp_out_byte == 8'h00 && rsp_out_last, "end marker malformed")
   `ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) && !reset |-> !rsp_valid && !req_stall, "not idle after reset")

endmodule

bind base64_stream_codec b64c_checker u_chk (.*);
